// ----- design/sfi_pkg.sv -----
`default_nettype none
package sfi_pkg;

   localparam int unsigned FRAC_BITS_DEF = 16;

   // action codes
   localparam logic [2:0] ACT_SEEK    = 3'd0;
   localparam logic [2:0] ACT_FLEE    = 3'd1;
   localparam logic [2:0] ACT_PURSUIT = 3'd2;
   localparam logic [2:0] ACT_EVADE   = 3'd3;
   localparam logic [2:0] ACT_UPDATE  = 3'd4;
   localparam logic [2:0] ACT_PLACE   = 3'd5;

   // register indexes
   localparam logic [0:0] REG_MAX_SPEED    = 1'b0;
   localparam logic [0:0] REG_INVERSE_MASS = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE, S_DIFF, S_SQX, S_SQY, S_SQS, S_SQW, S_LEN,
      S_SPD_MUL, S_SPD_DIV0, S_SPD_DIVW,
      S_SCX_MUL, S_SCX_DIV0, S_SCX_DIVW, S_SCY_MUL, S_SCY_DIV0, S_SCY_DIVW,
      S_SC_DONE, S_KDIVW, S_PRX_MUL, S_PRX, S_PRY,
      S_IMX, S_IMY, S_IMS, S_RESP
   } state_type;

   typedef enum logic [1:0] {
      PH_SEEK, PH_DIST, PH_UPD_S, PH_UPD_V
   } phase_type;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return sat33(33'(a) + 33'(b));
   endfunction

   function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return sat33(33'(a) - 33'(b));
   endfunction

   function automatic logic signed [31:0] sneg(input logic signed [31:0] a);
      return sat33(-33'(a));
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] a);
      return a[31] ? 32'(-a) : 32'(a);
   endfunction

   // signed value from a wide magnitude, saturated
   function automatic logic signed [31:0] with_sign(input logic [63:0] m, input logic neg);
      logic big;
      logic signed [31:0] r;
      big = |m[63:31];
      if (neg) begin
         r = big ? 32'sh8000_0000 : -$signed(m[31:0]);
      end else begin
         r = (big || (m[30:0] == 31'h7fff_ffff)) ? 32'sh7fff_ffff : $signed(m[31:0]);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- design/sfi_mul.sv -----
`default_nettype none
module sfi_mul (
   input  wire logic        clock,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic      [63:0] p
);
   logic [63:0] p_ff;
   logic [63:0] p_in;

   assign p_in = 64'(a) * 64'(b);

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;
endmodule
`default_nettype wire

// ----- design/sfi_div.sv -----
`default_nettype none
module sfi_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic      [63:0] quotient
);
   logic [31:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 32'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'h3f) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ----- design/sfi_sqrt.sv -----
`default_nettype none
module sfi_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic             done,
   output logic      [31:0] root
);
   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [35:0] rem2;
   logic [35:0] trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem2    = {rem_ff, rad_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // bring down two bits, settle one root bit
         rad_in = {rad_ff[61:0], 2'b00};
         if (rem2 >= trial) begin
            rem_in  = 34'(rem2 - trial);
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem2[33:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'h1f) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

// ----- design/steering_force_integrator.sv -----
`default_nettype none
// 2D steering for one host in signed fixed point with FRAC_BITS fractional
// bits. Each request beat runs one action (seek, flee, pursuit, evade,
// update, place) against the stored host position, velocity and steering
// accumulator, and returns one response beat with the state after it. One
// item is in flight at a time: req_ready is high only while idle, and the
// result waits in the response registers until taken. A sequencer reuses a
// registered 32x32 multiplier, a 64/32 restoring divider (one quotient bit a
// cycle) and an integer square root (one root bit a cycle). Those two
// iterative units set the latency: place and unused actions use neither;
// seek and flee use one root and up to three divisions; pursuit and evade
// use two roots and up to three divisions; update uses two length checks,
// each with two divisions when it truncates.
module steering_force_integrator #(
   parameter int unsigned FRAC_BITS = sfi_pkg::FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic        [2:0]  req_action,
   input  wire logic signed [31:0] req_target_x,
   input  wire logic signed [31:0] req_target_y,
   input  wire logic signed [31:0] req_target_vx,
   input  wire logic signed [31:0] req_target_vy,
   input  wire logic        [30:0] req_slowing_radius,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed      [31:0] rsp_pos_x,
   output logic signed      [31:0] rsp_pos_y,
   output logic signed      [31:0] rsp_vel_x,
   output logic signed      [31:0] rsp_vel_y,
   output logic signed      [31:0] rsp_steer_x,
   output logic signed      [31:0] rsp_steer_y,
   input  wire logic               csr_we,
   input  wire logic        [0:0]  csr_index,
   input  wire logic        [30:0] csr_wdata
);
   localparam logic [30:0] ONE_Q = 31'(64'(1) << FRAC_BITS);

   sfi_pkg::state_type state_ff, state_in;
   sfi_pkg::phase_type phase_ff, phase_in;

   logic        [2:0]  act_ff, act_in;
   logic signed [31:0] tx_ff, tx_in, ty_ff, ty_in;
   logic signed [31:0] tvx_ff, tvx_in, tvy_ff, tvy_in;
   logic        [30:0] rad_ff, rad_in;
   logic signed [31:0] wx_ff, wx_in, wy_ff, wy_in;
   logic        [31:0] len_ff, len_in;
   logic        [31:0] spd_ff, spd_in;
   logic signed [31:0] rx_ff, rx_in, ry_ff, ry_in;
   logic        [63:0] acc_ff, acc_in;
   logic        [31:0] k_ff, k_in;
   logic signed [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [31:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic signed [31:0] str_x_ff, str_x_in, str_y_ff, str_y_in;
   logic        [30:0] ms_ff, ms_in, im_ff, im_in;

   // shared units
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic        div_start, div_done;
   logic [63:0] div_dividend, div_quotient;
   logic [31:0] div_divisor;
   logic        sqrt_start, sqrt_done;
   logic [63:0] sqrt_radicand;
   logic [31:0] sqrt_root;

   sfi_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   sfi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   sfi_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_radicand),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   logic in_radius;
   logic over_max;
   logic is_flee;
   logic [63:0] pred_m;

   assign in_radius = (len_ff <= {1'b0, rad_ff});
   assign over_max  = (len_ff > {1'b0, ms_ff});
   assign is_flee   = (act_ff == sfi_pkg::ACT_FLEE) || (act_ff == sfi_pkg::ACT_EVADE);
   // predicted offset: pursuit takes a fractional lookahead, evade whole steps
   assign pred_m    = (act_ff == sfi_pkg::ACT_PURSUIT) ? (mul_p >> FRAC_BITS) : mul_p;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sfi_pkg::S_IDLE: begin
            if (req_valid) begin
               case (req_action)
                  sfi_pkg::ACT_SEEK, sfi_pkg::ACT_FLEE,
                  sfi_pkg::ACT_PURSUIT, sfi_pkg::ACT_EVADE: state_in = sfi_pkg::S_DIFF;
                  sfi_pkg::ACT_UPDATE:                      state_in = sfi_pkg::S_SQX;
                  default:                                  state_in = sfi_pkg::S_RESP;
               endcase
            end
         end
         sfi_pkg::S_DIFF: state_in = sfi_pkg::S_SQX;
         sfi_pkg::S_SQX:  state_in = sfi_pkg::S_SQY;
         sfi_pkg::S_SQY:  state_in = sfi_pkg::S_SQS;
         sfi_pkg::S_SQS:  state_in = sfi_pkg::S_SQW;
         sfi_pkg::S_SQW: begin
            if (sqrt_done) state_in = sfi_pkg::S_LEN;
         end
         sfi_pkg::S_LEN: begin
            case (phase_ff)
               sfi_pkg::PH_SEEK: begin
                  state_in = (in_radius && (rad_ff != '0)) ? sfi_pkg::S_SPD_MUL
                                                           : sfi_pkg::S_SCX_MUL;
               end
               sfi_pkg::PH_DIST: begin
                  state_in = (ms_ff == '0) ? sfi_pkg::S_PRX_MUL : sfi_pkg::S_KDIVW;
               end
               default: begin
                  state_in = over_max ? sfi_pkg::S_SCX_MUL : sfi_pkg::S_SC_DONE;
               end
            endcase
         end
         sfi_pkg::S_SPD_MUL:  state_in = sfi_pkg::S_SPD_DIV0;
         sfi_pkg::S_SPD_DIV0: state_in = sfi_pkg::S_SPD_DIVW;
         sfi_pkg::S_SPD_DIVW: begin
            if (div_done) state_in = sfi_pkg::S_SCX_MUL;
         end
         sfi_pkg::S_SCX_MUL: begin
            state_in = (len_ff == '0) ? sfi_pkg::S_SC_DONE : sfi_pkg::S_SCX_DIV0;
         end
         sfi_pkg::S_SCX_DIV0: state_in = sfi_pkg::S_SCX_DIVW;
         sfi_pkg::S_SCX_DIVW: begin
            if (div_done) state_in = sfi_pkg::S_SCY_MUL;
         end
         sfi_pkg::S_SCY_MUL:  state_in = sfi_pkg::S_SCY_DIV0;
         sfi_pkg::S_SCY_DIV0: state_in = sfi_pkg::S_SCY_DIVW;
         sfi_pkg::S_SCY_DIVW: begin
            if (div_done) state_in = sfi_pkg::S_SC_DONE;
         end
         sfi_pkg::S_SC_DONE: begin
            state_in = (phase_ff == sfi_pkg::PH_UPD_S) ? sfi_pkg::S_IMX : sfi_pkg::S_RESP;
         end
         sfi_pkg::S_KDIVW: begin
            if (div_done) state_in = sfi_pkg::S_PRX_MUL;
         end
         sfi_pkg::S_PRX_MUL: state_in = sfi_pkg::S_PRX;
         sfi_pkg::S_PRX:     state_in = sfi_pkg::S_PRY;
         sfi_pkg::S_PRY:     state_in = sfi_pkg::S_DIFF;
         sfi_pkg::S_IMX:     state_in = sfi_pkg::S_IMY;
         sfi_pkg::S_IMY:     state_in = sfi_pkg::S_IMS;
         sfi_pkg::S_IMS:     state_in = sfi_pkg::S_SQX;
         sfi_pkg::S_RESP: begin
            if (rsp_ready) state_in = sfi_pkg::S_IDLE;
         end
         default: state_in = sfi_pkg::S_IDLE;
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      logic signed [31:0] f_x, f_y, s_y, v_x, v_y;
      phase_in  = phase_ff;
      act_in    = act_ff;
      tx_in     = tx_ff;
      ty_in     = ty_ff;
      tvx_in    = tvx_ff;
      tvy_in    = tvy_ff;
      rad_in    = rad_ff;
      wx_in     = wx_ff;
      wy_in     = wy_ff;
      len_in    = len_ff;
      spd_in    = spd_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      acc_in    = acc_ff;
      k_in      = k_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      vel_x_in  = vel_x_ff;
      vel_y_in  = vel_y_ff;
      str_x_in  = str_x_ff;
      str_y_in  = str_y_ff;
      ms_in     = ms_ff;
      im_in     = im_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      sqrt_start    = 1'b0;
      sqrt_radicand = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      f_x = '0;
      f_y = '0;
      s_y = '0;
      v_x = '0;
      v_y = '0;

      case (state_ff)
         sfi_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               act_in = req_action;
               tx_in  = req_target_x;
               ty_in  = req_target_y;
               tvx_in = req_target_vx;
               tvy_in = req_target_vy;
               // only seek honors the slowing radius
               rad_in = (req_action == sfi_pkg::ACT_SEEK) ? req_slowing_radius : '0;
               case (req_action)
                  sfi_pkg::ACT_SEEK, sfi_pkg::ACT_FLEE: phase_in = sfi_pkg::PH_SEEK;
                  sfi_pkg::ACT_PURSUIT, sfi_pkg::ACT_EVADE: phase_in = sfi_pkg::PH_DIST;
                  sfi_pkg::ACT_UPDATE: begin
                     phase_in = sfi_pkg::PH_UPD_S;
                     wx_in    = str_x_ff;
                     wy_in    = str_y_ff;
                  end
                  sfi_pkg::ACT_PLACE: begin
                     pos_x_in = req_target_x;
                     pos_y_in = req_target_y;
                     vel_x_in = req_target_vx;
                     vel_y_in = req_target_vy;
                  end
                  default: ;
               endcase
            end
         end
         sfi_pkg::S_DIFF: begin
            wx_in = sfi_pkg::ssub(tx_ff, pos_x_ff);
            wy_in = sfi_pkg::ssub(ty_ff, pos_y_ff);
         end
         sfi_pkg::S_SQX: begin
            mul_a = sfi_pkg::mag32(wx_ff);
            mul_b = sfi_pkg::mag32(wx_ff);
         end
         sfi_pkg::S_SQY: begin
            acc_in = mul_p;
            mul_a  = sfi_pkg::mag32(wy_ff);
            mul_b  = sfi_pkg::mag32(wy_ff);
         end
         sfi_pkg::S_SQS: begin
            sqrt_start    = 1'b1;
            sqrt_radicand = acc_ff + mul_p;
         end
         sfi_pkg::S_SQW: begin
            if (sqrt_done) len_in = sqrt_root;
         end
         sfi_pkg::S_LEN: begin
            case (phase_ff)
               sfi_pkg::PH_SEEK: begin
                  // inside the radius slow down; zero radius holds only zero distance
                  if (!in_radius) spd_in = {1'b0, ms_ff};
                  else if (rad_ff == '0) spd_in = '0;
               end
               sfi_pkg::PH_DIST: begin
                  if (ms_ff == '0) begin
                     k_in = '1;
                  end else begin
                     div_start    = 1'b1;
                     div_dividend = (act_ff == sfi_pkg::ACT_PURSUIT)
                                    ? (64'(len_ff) << FRAC_BITS) : 64'(len_ff);
                     div_divisor  = {1'b0, ms_ff};
                  end
               end
               default: begin
                  if (over_max) begin
                     spd_in = {1'b0, ms_ff};
                  end else begin
                     rx_in = wx_ff;
                     ry_in = wy_ff;
                  end
               end
            endcase
         end
         sfi_pkg::S_SPD_MUL: begin
            mul_a = {1'b0, ms_ff};
            mul_b = len_ff;
         end
         sfi_pkg::S_SPD_DIV0: begin
            div_start    = 1'b1;
            div_dividend = mul_p;
            div_divisor  = {1'b0, rad_ff};
         end
         sfi_pkg::S_SPD_DIVW: begin
            if (div_done) spd_in = div_quotient[31:0];
         end
         sfi_pkg::S_SCX_MUL: begin
            if (len_ff == '0) begin
               rx_in = '0;
               ry_in = '0;
            end
            mul_a = sfi_pkg::mag32(wx_ff);
            mul_b = spd_ff;
         end
         sfi_pkg::S_SCX_DIV0, sfi_pkg::S_SCY_DIV0: begin
            div_start    = 1'b1;
            div_dividend = mul_p;
            div_divisor  = len_ff;
         end
         sfi_pkg::S_SCX_DIVW: begin
            if (div_done) rx_in = sfi_pkg::with_sign(div_quotient, wx_ff[31]);
         end
         sfi_pkg::S_SCY_MUL: begin
            mul_a = sfi_pkg::mag32(wy_ff);
            mul_b = spd_ff;
         end
         sfi_pkg::S_SCY_DIVW: begin
            if (div_done) ry_in = sfi_pkg::with_sign(div_quotient, wy_ff[31]);
         end
         sfi_pkg::S_SC_DONE: begin
            case (phase_ff)
               sfi_pkg::PH_SEEK: begin
                  f_x = sfi_pkg::ssub(rx_ff, vel_x_ff);
                  f_y = sfi_pkg::ssub(ry_ff, vel_y_ff);
                  if (is_flee) begin
                     f_x = sfi_pkg::sneg(f_x);
                     f_y = sfi_pkg::sneg(f_y);
                  end
                  str_x_in = sfi_pkg::sadd(str_x_ff, f_x);
                  str_y_in = sfi_pkg::sadd(str_y_ff, f_y);
               end
               sfi_pkg::PH_UPD_S: ;
               default: begin
                  // velocity settled: commit it and advance position
                  vel_x_in = rx_ff;
                  vel_y_in = ry_ff;
                  pos_x_in = sfi_pkg::sadd(pos_x_ff, rx_ff);
                  pos_y_in = sfi_pkg::sadd(pos_y_ff, ry_ff);
               end
            endcase
         end
         sfi_pkg::S_KDIVW: begin
            if (div_done) begin
               k_in = (div_quotient[63:32] != '0) ? '1 : div_quotient[31:0];
            end
         end
         sfi_pkg::S_PRX_MUL: begin
            mul_a = sfi_pkg::mag32(tvx_ff);
            mul_b = k_ff;
         end
         sfi_pkg::S_PRX: begin
            tx_in = sfi_pkg::sadd(tx_ff, sfi_pkg::with_sign(pred_m, tvx_ff[31]));
            mul_a = sfi_pkg::mag32(tvy_ff);
            mul_b = k_ff;
         end
         sfi_pkg::S_PRY: begin
            ty_in    = sfi_pkg::sadd(ty_ff, sfi_pkg::with_sign(pred_m, tvy_ff[31]));
            phase_in = sfi_pkg::PH_SEEK;
            rad_in   = '0;
         end
         sfi_pkg::S_IMX: begin
            mul_a = sfi_pkg::mag32(rx_ff);
            mul_b = {1'b0, im_ff};
         end
         sfi_pkg::S_IMY: begin
            rx_in = sfi_pkg::with_sign(mul_p >> FRAC_BITS, rx_ff[31]);
            mul_a = sfi_pkg::mag32(ry_ff);
            mul_b = {1'b0, im_ff};
         end
         sfi_pkg::S_IMS: begin
            // scaled steering replaces the accumulator, then feeds velocity
            s_y      = sfi_pkg::with_sign(mul_p >> FRAC_BITS, ry_ff[31]);
            str_x_in = rx_ff;
            str_y_in = s_y;
            v_x      = sfi_pkg::sadd(vel_x_ff, rx_ff);
            v_y      = sfi_pkg::sadd(vel_y_ff, s_y);
            wx_in    = v_x;
            wy_in    = v_y;
            phase_in = sfi_pkg::PH_UPD_V;
         end
         sfi_pkg::S_RESP: begin
            rsp_valid = 1'b1;
         end
         default: ;
      endcase

      if (csr_we) begin
         if (csr_index == sfi_pkg::REG_MAX_SPEED) ms_in = csr_wdata;
         else                                     im_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfi_pkg::S_IDLE;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         vel_x_ff <= '0;
         vel_y_ff <= '0;
         str_x_ff <= '0;
         str_y_ff <= '0;
         ms_ff    <= ONE_Q;
         im_ff    <= ONE_Q;
      end else begin
         state_ff <= state_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         vel_x_ff <= vel_x_in;
         vel_y_ff <= vel_y_in;
         str_x_ff <= str_x_in;
         str_y_ff <= str_y_in;
         ms_ff    <= ms_in;
         im_ff    <= im_in;
      end
      phase_ff <= phase_in;
      act_ff   <= act_in;
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      tvx_ff   <= tvx_in;
      tvy_ff   <= tvy_in;
      rad_ff   <= rad_in;
      wx_ff    <= wx_in;
      wy_ff    <= wy_in;
      len_ff   <= len_in;
      spd_ff   <= spd_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      acc_ff   <= acc_in;
      k_ff     <= k_in;
   end

   assign rsp_pos_x   = pos_x_ff;
   assign rsp_pos_y   = pos_y_ff;
   assign rsp_vel_x   = vel_x_ff;
   assign rsp_vel_y   = vel_y_ff;
   assign rsp_steer_x = str_x_ff;
   assign rsp_steer_y = str_y_ff;
endmodule
`default_nettype wire

// ----- test/steering_force_integrator_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module steering_force_integrator_test;

   localparam int unsigned FB = sfi_pkg::FRAC_BITS_DEF;
   localparam longint unsigned M32 = 64'hFFFF_FFFF;
   localparam longint CYCLE_LIMIT = 3_000_000;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] tx, ty, tvx, tvy;
      logic [30:0]        radius;
   } steer_cmd_type;

   typedef struct packed {
      logic signed [31:0] px, py, vx, vy, sx, sy;
   } host_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_action = '0;
   logic signed [31:0] req_target_x = '0, req_target_y = '0;
   logic signed [31:0] req_target_vx = '0, req_target_vy = '0;
   logic [30:0] req_slowing_radius = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_vel_x, rsp_vel_y, rsp_steer_x, rsp_steer_y;
   logic csr_we = 1'b0;
   logic [0:0] csr_index = '0;
   logic [30:0] csr_wdata = '0;

   steering_force_integrator dut (.*);

   always #6 clock = ~clock;

   // Predictor state: mirror of the host kept by the block.
   longint unsigned top_speed, inv_mass;
   logic signed [31:0] hpx, hpy, hvx, hvy, acc_x, acc_y;

   steer_cmd_type  pending_cmds[$];
   host_state_type expected_states[$];
   int          send_idle_pct, recv_idle_pct;
   int          hold_off;
   int          errors;
   longint      cycles;
   int          beats_in, beats_out;
   int          act_count[8];

   function automatic logic signed [31:0] clamp(longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return 32'(v);
   endfunction

   function automatic longint unsigned absval(logic signed [31:0] c);
      return c < 0 ? longint'(-longint'(c)) : longint'(c);
   endfunction

   function automatic logic signed [31:0] signed_mag(longint unsigned m, logic neg);
      if (m > 64'd2147483648) m = 64'd2147483648;
      return clamp(neg ? -longint'(m) : longint'(m));
   endfunction

   function automatic longint unsigned root(longint unsigned v);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned magnitude(logic signed [31:0] x, logic signed [31:0] y);
      longint unsigned ax = absval(x), ay = absval(y);
      return root(ax * ax + ay * ay);
   endfunction

   // Rescale (x, y) to magnitude m given its length; zero stays zero.
   function automatic void rescale(inout logic signed [31:0] x, inout logic signed [31:0] y,
                                   input longint unsigned m, input longint unsigned len);
      if (len == 0) begin
         x = 0;
         y = 0;
      end else begin
         x = signed_mag(absval(x) * m / len, x < 0);
         y = signed_mag(absval(y) * m / len, y < 0);
      end
   endfunction

   function automatic void limit_len(inout logic signed [31:0] x, inout logic signed [31:0] y,
                                     input longint unsigned m);
      longint unsigned len = magnitude(x, y);
      if (len > m) rescale(x, y, m, len);
   endfunction

   function automatic void seek_toward(input logic signed [31:0] tx,
                                       input logic signed [31:0] ty,
                                       input longint unsigned radius,
                                       output logic signed [31:0] fx,
                                       output logic signed [31:0] fy);
      logic signed [31:0] dx, dy;
      longint unsigned len, speed;
      dx = clamp(longint'(tx) - longint'(hpx));
      dy = clamp(longint'(ty) - longint'(hpy));
      len = magnitude(dx, dy);
      if (len <= radius) speed = radius != 0 ? top_speed * len / radius : 0;
      else speed = top_speed;
      rescale(dx, dy, speed, len);
      fx = clamp(longint'(dx) - longint'(hvx));
      fy = clamp(longint'(dy) - longint'(hvy));
   endfunction

   function automatic logic signed [31:0] project(logic signed [31:0] t, logic signed [31:0] v,
                                                  longint unsigned k, int sh);
      longint unsigned m = (absval(v) * k) >> sh;
      return clamp(longint'(t) + longint'(signed_mag(m, v < 0)));
   endfunction

   function automatic longint unsigned lookahead(steer_cmd_type c, int sh);
      longint unsigned k, d;
      d = magnitude(clamp(longint'(c.tx) - longint'(hpx)), clamp(longint'(c.ty) - longint'(hpy)));
      k = top_speed != 0 ? (d << sh) / top_speed : M32;
      return k > M32 ? M32 : k;
   endfunction

   // Advance the host model by one command and return the state after it.
   function automatic host_state_type steer_step(steer_cmd_type c);
      logic signed [31:0] fx, fy, px, py;
      longint unsigned k;
      case (c.action)
         sfi_pkg::ACT_SEEK: seek_toward(c.tx, c.ty, c.radius, fx, fy);
         sfi_pkg::ACT_FLEE: begin
            seek_toward(c.tx, c.ty, 0, fx, fy);
            fx = clamp(-longint'(fx));
            fy = clamp(-longint'(fy));
         end
         sfi_pkg::ACT_PURSUIT: begin
            k = lookahead(c, FB);
            seek_toward(project(c.tx, c.tvx, k, FB), project(c.ty, c.tvy, k, FB), 0, fx, fy);
         end
         sfi_pkg::ACT_EVADE: begin
            k = lookahead(c, 0);
            px = project(c.tx, c.tvx, k, 0);
            py = project(c.ty, c.tvy, k, 0);
            seek_toward(px, py, 0, fx, fy);
            fx = clamp(-longint'(fx));
            fy = clamp(-longint'(fy));
         end
         default: begin
            fx = 0;
            fy = 0;
         end
      endcase
      if (c.action <= sfi_pkg::ACT_EVADE) begin
         acc_x = clamp(longint'(acc_x) + longint'(fx));
         acc_y = clamp(longint'(acc_y) + longint'(fy));
      end else if (c.action == sfi_pkg::ACT_UPDATE) begin
         limit_len(acc_x, acc_y, top_speed);
         acc_x = signed_mag((absval(acc_x) * inv_mass) >> FB, acc_x < 0);
         acc_y = signed_mag((absval(acc_y) * inv_mass) >> FB, acc_y < 0);
         hvx = clamp(longint'(hvx) + longint'(acc_x));
         hvy = clamp(longint'(hvy) + longint'(acc_y));
         limit_len(hvx, hvy, top_speed);
         hpx = clamp(longint'(hpx) + longint'(hvx));
         hpy = clamp(longint'(hpy) + longint'(hvy));
      end else if (c.action == sfi_pkg::ACT_PLACE) begin
         hpx = c.tx;
         hpy = c.ty;
         hvx = c.tvx;
         hvy = c.tvy;
      end
      return '{hpx, hpy, hvx, hvy, acc_x, acc_y};
   endfunction

   // Driver: hold the beat until accepted, then advance or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            steer_cmd_type c;
            c = pending_cmds.pop_front();
            req_valid <= 1'b1;
            req_action <= c.action;
            req_target_x <= c.tx;
            req_target_y <= c.ty;
            req_target_vx <= c.tvx;
            req_target_vy <= c.tvy;
            req_slowing_radius <= c.radius;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Predict on every accepted request beat.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expected_states.push_back(steer_step({req_action, req_target_x, req_target_y,
                                               req_target_vx, req_target_vy,
                                               req_slowing_radius}));
         beats_in++;
         act_count[req_action]++;
      end
   end

   // Receiver ready: random idling, plus a long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // Monitor: compare each response beat with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         beats_out++;
         if (expected_states.size() == 0) begin
            $error("response beat with no prediction pending");
            errors++;
         end else begin
            host_state_type e;
            e = expected_states.pop_front();
            if (rsp_pos_x !== e.px) begin
               $error("pos_x expected %0d got %0d", e.px, rsp_pos_x); errors++;
            end
            if (rsp_pos_y !== e.py) begin
               $error("pos_y expected %0d got %0d", e.py, rsp_pos_y); errors++;
            end
            if (rsp_vel_x !== e.vx) begin
               $error("vel_x expected %0d got %0d", e.vx, rsp_vel_x); errors++;
            end
            if (rsp_vel_y !== e.vy) begin
               $error("vel_y expected %0d got %0d", e.vy, rsp_vel_y); errors++;
            end
            if (rsp_steer_x !== e.sx) begin
               $error("steer_x expected %0d got %0d", e.sx, rsp_steer_x); errors++;
            end
            if (rsp_steer_y !== e.sy) begin
               $error("steer_y expected %0d got %0d", e.sy, rsp_steer_y); errors++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("steering_force_integrator_test: FAIL");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'sh7fff_ffff - 32'($urandom_range(3));
         2: return 32'sh8000_0000 + 32'($urandom_range(3));
         default: return $signed(32'($urandom_range(400 << FB))) - (200 <<< FB);
      endcase
   endfunction

   function automatic steer_cmd_type rand_cmd();
      steer_cmd_type c;
      int r = $urandom_range(99);
      if (r < 25) c.action = sfi_pkg::ACT_SEEK;
      else if (r < 37) c.action = sfi_pkg::ACT_FLEE;
      else if (r < 52) c.action = sfi_pkg::ACT_PURSUIT;
      else if (r < 66) c.action = sfi_pkg::ACT_EVADE;
      else if (r < 90) c.action = sfi_pkg::ACT_UPDATE;
      else if (r < 97) c.action = sfi_pkg::ACT_PLACE;
      else c.action = 3'($urandom_range(6, 7));
      c.tx = rand_coord();
      c.ty = rand_coord();
      c.tvx = $urandom_range(3) == 0 ? $urandom : rand_coord() >>> 4;
      c.tvy = $urandom_range(3) == 0 ? $urandom : rand_coord() >>> 4;
      case ($urandom_range(3))
         0: c.radius = 31'($urandom);
         1: c.radius = '0;
         default: c.radius = 31'($urandom_range(300 << FB));
      endcase
      return c;
   endfunction

   task automatic drain();
      while (pending_cmds.size() != 0 || req_valid || expected_states.size() != 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [30:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == sfi_pkg::REG_MAX_SPEED) top_speed = val;
      else inv_mass = val;
   endtask

   task automatic random_phase(input int n);
      repeat (n) pending_cmds.push_back(rand_cmd());
      drain();
   endtask

   initial begin
      steer_cmd_type c;
      top_speed = 64'd1 << FB;
      inv_mass = 64'd1 << FB;
      {hpx, hpy, hvx, hvy, acc_x, acc_y} = '0;
      send_idle_pct = 6;
      recv_idle_pct = 71;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero distance, radius cases, extremes, every action.
      pending_cmds.push_back('{sfi_pkg::ACT_SEEK, 0, 0, 0, 0, 31'd100});
      pending_cmds.push_back('{sfi_pkg::ACT_SEEK, 10 << FB, 0, 0, 0, 31'd0});
      pending_cmds.push_back('{sfi_pkg::ACT_SEEK, 3 << FB, 4 << FB, 0, 0, 31'(100 << FB)});
      pending_cmds.push_back('{sfi_pkg::ACT_FLEE, 0, 0, 0, 0, 31'd0});
      pending_cmds.push_back('{sfi_pkg::ACT_FLEE, -5 << FB, 7 << FB, 0, 0, 31'h7fff_ffff});
      pending_cmds.push_back('{sfi_pkg::ACT_PURSUIT, 20 << FB, -9 << FB, 1 << FB, 2 << FB,
                               31'd0});
      pending_cmds.push_back('{sfi_pkg::ACT_EVADE, 50 << FB, 30 << FB, -1 << FB, 3 << FB,
                               31'd0});
      pending_cmds.push_back('{sfi_pkg::ACT_UPDATE, 0, 0, 0, 0, 31'd0});
      pending_cmds.push_back('{sfi_pkg::ACT_PLACE, 32'sh7fff_ffff, 32'sh8000_0000,
                               32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff});
      pending_cmds.push_back('{sfi_pkg::ACT_SEEK, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0,
                               31'd0});
      pending_cmds.push_back('{sfi_pkg::ACT_PURSUIT, 32'sh8000_0000, 32'sh7fff_ffff,
                               32'sh7fff_ffff, 32'sh8000_0000, 31'd0});
      pending_cmds.push_back('{sfi_pkg::ACT_EVADE, 32'sh7fff_ffff, 32'sh7fff_ffff,
                               32'sh8000_0000, 32'sh8000_0000, 31'd0});
      pending_cmds.push_back('{sfi_pkg::ACT_UPDATE, 0, 0, 0, 0, 31'd0});
      pending_cmds.push_back('{3'd6, -1, -1, -1, -1, 31'h7fff_ffff});
      pending_cmds.push_back('{3'd7, 0, 0, 0, 0, 31'd0});
      pending_cmds.push_back('{sfi_pkg::ACT_PLACE, 0, 0, 0, 0, 31'd0});
      drain();

      // Zero max speed: lookahead saturates.
      write_reg(sfi_pkg::REG_MAX_SPEED, '0);
      write_reg(sfi_pkg::REG_INVERSE_MASS, 31'h7fff_ffff);
      pending_cmds.push_back('{sfi_pkg::ACT_PURSUIT, 5 << FB, 5 << FB, 1 << FB, -1 << FB,
                               31'd0});
      pending_cmds.push_back('{sfi_pkg::ACT_EVADE, 5 << FB, 5 << FB, 1 << FB, -1 << FB,
                               31'd0});
      pending_cmds.push_back('{sfi_pkg::ACT_UPDATE, 0, 0, 0, 0, 31'd0});
      drain();

      write_reg(sfi_pkg::REG_MAX_SPEED, 31'd1 << FB);
      write_reg(sfi_pkg::REG_INVERSE_MASS, 31'd1 << FB);
      random_phase(200);

      // Pressure: stall the receiver while the sender keeps offering.
      hold_off = 1500;
      random_phase(40);

      send_idle_pct = 71;
      recv_idle_pct = 6;
      write_reg(sfi_pkg::REG_MAX_SPEED, 31'h7fff_ffff);
      write_reg(sfi_pkg::REG_INVERSE_MASS, '0);
      random_phase(150);

      write_reg(sfi_pkg::REG_MAX_SPEED, 31'(3 << FB));
      write_reg(sfi_pkg::REG_INVERSE_MASS, 31'(1 << (FB - 2)));
      random_phase(200);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(sfi_pkg::REG_MAX_SPEED, 31'd1);
      write_reg(sfi_pkg::REG_INVERSE_MASS, 31'(2 << FB));
      random_phase(100);
      write_reg(sfi_pkg::REG_MAX_SPEED, 31'($urandom_range(1, 10 << FB)));
      write_reg(sfi_pkg::REG_INVERSE_MASS, 31'($urandom));
      random_phase(200);

      $display("run covered %0d request beats and %0d response beats", beats_in, beats_out);
      $display("actions seek/flee/pursuit/evade/update/place: %0d %0d %0d %0d %0d %0d",
               act_count[0], act_count[1], act_count[2], act_count[3], act_count[4],
               act_count[5]);
      if (errors == 0 && expected_states.size() == 0) begin
         $display("steering_force_integrator_test: PASS");
      end else begin
         $display("steering_force_integrator_test: FAIL");
      end
      $finish;
   end

   initial begin
      errors = 0;
      cycles = 0;
      hold_off = 0;
      beats_in = 0;
      beats_out = 0;
      foreach (act_count[i]) act_count[i] = 0;
   end
endmodule
`default_nettype wire
